FILE: rtl/rgba_blend_pkg.sv
`default_nettype none
package rgba_blend_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam logic [16:0] ALPHA_ONE = 17'd65536;

    // request kinds
    localparam logic [1:0] REQ_BLEND  = 2'd0;
    localparam logic [1:0] REQ_READ   = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DROP    = 2'd1;
    localparam logic [1:0] ST_CLEARED = 2'd2;

    // register indexes
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_BG_RGB = 2'd2;
    localparam logic [1:0] REG_BG_EN  = 2'd3;

    // datapath operations
    localparam logic [3:0] OP_NOP      = 4'd0;
    localparam logic [3:0] OP_LOAD     = 4'd1;
    localparam logic [3:0] OP_ADDR     = 4'd2;
    localparam logic [3:0] OP_READ     = 4'd3;
    localparam logic [3:0] OP_MULW     = 4'd4;
    localparam logic [3:0] OP_DEN      = 4'd5;
    localparam logic [3:0] OP_PROD     = 4'd6;
    localparam logic [3:0] OP_NUM      = 4'd7;
    localparam logic [3:0] OP_DIVINIT  = 4'd8;
    localparam logic [3:0] OP_DIVSTEP  = 4'd9;
    localparam logic [3:0] OP_DIVEND   = 4'd10;
    localparam logic [3:0] OP_SWEEP    = 4'd11;
    localparam logic [3:0] OP_RSTSWEEP = 4'd12;
    localparam logic [3:0] OP_OUT      = 4'd13;

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] chan;
    } cmd_t;

    typedef struct packed {
        logic [1:0] req;
        logic       drop;
        logic       sweep_last;
    } sts_t;

endpackage
`default_nettype wire

FILE: rtl/rgba_blend_dp.sv
`default_nettype none
module rgba_blend_dp #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  rgba_blend_pkg::cmd_t cmd,
    output rgba_blend_pkg::sts_t sts,
    input  wire  [1:0]           req_type,
    input  wire  [15:0]          pos_x,
    input  wire  [15:0]          pos_y,
    input  wire  [7:0]           src_red,
    input  wire  [7:0]           src_green,
    input  wire  [7:0]           src_blue,
    input  wire  [16:0]          src_alpha,
    input  wire  [8:0]           canvas_width,
    input  wire  [8:0]           canvas_height,
    input  wire  [23:0]          background_rgb,
    input  wire                  background_enable,
    output logic [1:0]           status,
    output logic [7:0]           out_red,
    output logic [7:0]           out_green,
    output logic [7:0]           out_blue,
    output logic [7:0]           out_alpha
);
    import rgba_blend_pkg::*;

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [31:0] mem [DEPTH];

    logic [1:0]        req_reg;
    logic [15:0]       x_reg, y_reg;
    logic [7:0]        src_reg [3];
    logic [16:0]       a_reg;
    logic              az_reg, inside_reg;
    logic [31:0]       fill_reg;
    logic [ADDR_W-1:0] idx_reg, sweep_reg;
    logic [31:0]       rd_reg;
    logic [24:0]       w_reg, a255_reg, den_reg;
    logic [7:0]        na_reg;
    logic [32:0]       prod_reg, num_reg;
    logic [33:0]       rem_reg, dsh_reg;
    logic [8:0]        q_reg;
    logic [7:0]        res_reg [3];
    logic [1:0]        out_status_reg;
    logic [31:0]       out_pix_reg;

    logic [15:0] wid, hgt;
    logic        inside_next;
    logic [31:0] idx_full;
    logic [7:0]  c_sel, p_sel;
    logic [33:0] rem_diff;
    logic [31:0] new_pix;

    // canvas in use is clipped to the store size
    always_comb begin
        wid = (16'(canvas_width) > 16'(MAX_WIDTH)) ? 16'(MAX_WIDTH) : 16'(canvas_width);
        hgt = (16'(canvas_height) > 16'(MAX_HEIGHT)) ? 16'(MAX_HEIGHT) : 16'(canvas_height);
        inside_next = !pos_x[15] && !pos_y[15] && (pos_x < wid) && (pos_y < hgt);
        idx_full = 32'(y_reg[14:0]) * 32'(MAX_WIDTH) + 32'(x_reg[14:0]);
        c_sel = src_reg[cmd.chan];
        case (cmd.chan)
            2'd0:    p_sel = rd_reg[31:24];
            2'd1:    p_sel = rd_reg[23:16];
            default: p_sel = rd_reg[15:8];
        endcase
        rem_diff = rem_reg - dsh_reg;
        new_pix = {res_reg[0], res_reg[1], res_reg[2], na_reg};
    end

    assign sts.req = req_reg;
    assign sts.drop = (req_reg == REQ_UNUSED) || !inside_reg
                      || ((req_reg == REQ_BLEND) && az_reg);
    assign sts.sweep_last = (sweep_reg == ADDR_W'(DEPTH - 1));

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                req_reg    <= req_type;
                x_reg      <= pos_x;
                y_reg      <= pos_y;
                src_reg[0] <= src_red;
                src_reg[1] <= src_green;
                src_reg[2] <= src_blue;
                a_reg      <= (src_alpha > ALPHA_ONE) ? ALPHA_ONE : src_alpha;
                az_reg     <= (src_alpha == 17'd0);
                inside_reg <= inside_next;
                fill_reg   <= background_enable ? {background_rgb, 8'hFF} : 32'd0;
            end
            OP_ADDR: idx_reg <= idx_full[ADDR_W-1:0];
            OP_MULW: begin
                w_reg    <= 25'(rd_reg[7:0]) * 25'(ALPHA_ONE - a_reg);
                a255_reg <= 25'(a_reg) * 25'd255;
            end
            OP_DEN: begin
                den_reg <= a255_reg + w_reg;
            end
            OP_PROD: prod_reg <= 33'(c_sel) * 33'(a255_reg);
            OP_NUM:  num_reg <= prod_reg + 33'(p_sel) * 33'(w_reg);
            OP_DIVINIT: begin
                rem_reg <= {num_reg, 1'b0} + 34'(den_reg);
                dsh_reg <= 34'({den_reg, 1'b0}) << 8;
                q_reg   <= 9'd0;
            end
            OP_DIVSTEP: begin
                if (rem_reg >= dsh_reg) begin
                    rem_reg <= rem_diff;
                    q_reg   <= {q_reg[7:0], 1'b1};
                end else begin
                    q_reg   <= {q_reg[7:0], 1'b0};
                end
                dsh_reg <= dsh_reg >> 1;
            end
            OP_DIVEND: res_reg[cmd.chan] <= (q_reg > 9'd255) ? 8'hFF : q_reg[7:0];
            OP_OUT: begin
                if (req_reg == REQ_CLEAR) begin
                    out_status_reg <= ST_CLEARED;
                    out_pix_reg    <= fill_reg;
                end else if (sts.drop) begin
                    out_status_reg <= ST_DROP;
                    out_pix_reg    <= 32'd0;
                end else if (req_reg == REQ_READ) begin
                    out_status_reg <= ST_OK;
                    out_pix_reg    <= rd_reg;
                end else begin
                    out_status_reg <= ST_OK;
                    out_pix_reg    <= new_pix;
                end
            end
            default: ;
        endcase
        // rounded alpha of the blend, ready with the denominator
        if (cmd.op == OP_DEN) begin
            na_reg <= (((a255_reg + w_reg) + 25'd32768) >> 16 > 25'd255) ? 8'hFF
                    : 8'(((a255_reg + w_reg) + 25'd32768) >> 16);
        end
    end

    // pixel store, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.op == OP_SWEEP) begin
            mem[sweep_reg] <= fill_reg;
        end else if (cmd.op == OP_RSTSWEEP) begin
            mem[sweep_reg] <= 32'd0;
        end else if (cmd.op == OP_OUT && req_reg == REQ_BLEND && !sts.drop) begin
            mem[idx_reg] <= new_pix;
        end
        if (cmd.op == OP_READ) begin
            rd_reg <= mem[idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_reg <= '0;
        end else if (cmd.op == OP_SWEEP || cmd.op == OP_RSTSWEEP) begin
            sweep_reg <= sts.sweep_last ? '0 : sweep_reg + 1'b1;
        end
    end

    assign status    = out_status_reg;
    assign out_red   = out_pix_reg[31:24];
    assign out_green = out_pix_reg[23:16];
    assign out_blue  = out_pix_reg[15:8];
    assign out_alpha = out_pix_reg[7:0];

endmodule
`default_nettype wire

FILE: rtl/rgba_blend_ctrl.sv
`default_nettype none
module rgba_blend_ctrl (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  wire                  m_tready,
    output rgba_blend_pkg::cmd_t cmd,
    input  rgba_blend_pkg::sts_t sts
);
    import rgba_blend_pkg::*;

    localparam logic [3:0] S_RSTSWEEP = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_ADDR     = 4'd2;
    localparam logic [3:0] S_READ     = 4'd3;
    localparam logic [3:0] S_MULW     = 4'd4;
    localparam logic [3:0] S_DEN      = 4'd5;
    localparam logic [3:0] S_PROD     = 4'd6;
    localparam logic [3:0] S_NUM      = 4'd7;
    localparam logic [3:0] S_DIVI     = 4'd8;
    localparam logic [3:0] S_DIVS     = 4'd9;
    localparam logic [3:0] S_DIVE     = 4'd10;
    localparam logic [3:0] S_SWEEP    = 4'd11;
    localparam logic [3:0] S_FIN      = 4'd12;

    logic [3:0] state_reg, state_next;
    logic [1:0] chan_reg, chan_next;
    logic [3:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = out_valid_reg;

    always_comb begin
        state_next     = state_reg;
        chan_next      = chan_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd.op         = OP_NOP;
        cmd.chan       = chan_reg;
        case (state_reg)
            S_RSTSWEEP: begin
                cmd.op = OP_RSTSWEEP;
                if (sts.sweep_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    state_next = S_ADDR;
                end
            end
            S_ADDR: begin
                if (sts.req == REQ_CLEAR) begin
                    state_next = S_SWEEP;
                end else if (sts.drop) begin
                    state_next = S_FIN;
                end else begin
                    cmd.op     = OP_ADDR;
                    state_next = S_READ;
                end
            end
            S_READ: begin
                cmd.op     = OP_READ;
                state_next = (sts.req == REQ_READ) ? S_FIN : S_MULW;
            end
            S_MULW: begin
                cmd.op     = OP_MULW;
                state_next = S_DEN;
            end
            S_DEN: begin
                cmd.op     = OP_DEN;
                chan_next  = 2'd0;
                state_next = S_PROD;
            end
            S_PROD: begin
                cmd.op     = OP_PROD;
                state_next = S_NUM;
            end
            S_NUM: begin
                cmd.op     = OP_NUM;
                state_next = S_DIVI;
            end
            S_DIVI: begin
                cmd.op     = OP_DIVINIT;
                cnt_next   = 4'd8;
                state_next = S_DIVS;
            end
            S_DIVS: begin
                cmd.op   = OP_DIVSTEP;
                cnt_next = cnt_reg - 4'd1;
                if (cnt_reg == 4'd0) state_next = S_DIVE;
            end
            S_DIVE: begin
                cmd.op = OP_DIVEND;
                if (chan_reg == 2'd2) begin
                    state_next = S_FIN;
                end else begin
                    chan_next  = chan_reg + 2'd1;
                    state_next = S_PROD;
                end
            end
            S_SWEEP: begin
                cmd.op = OP_SWEEP;
                if (sts.sweep_last) state_next = S_FIN;
            end
            S_FIN: begin
                if (slot_free) begin
                    cmd.op         = OP_OUT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_RSTSWEEP;
            chan_reg      <= 2'd0;
            cnt_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            chan_reg      <= chan_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_fin_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FIN && !out_valid_reg) |=> out_valid_reg)
        else $error("result not issued from finish state");
    a_div_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIVS && cnt_reg == 4'd0) |=> state_reg == S_DIVE)
        else $error("divider step count wrong");
    a_sweep_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SWEEP && sts.sweep_last) |=> state_reg == S_FIN)
        else $error("clear sweep did not finish");

endmodule
`default_nettype wire

FILE: rtl/rgba_source_over_pixel_blender_top.sv
// blend: three channels, each through a 9-step shared restoring divider;
//   clear writes every word of the store, one word per cycle
// one item at a time; the next item is taken as soon as the result is registered
// reset: aresetn synchronous active low; after reset a clearing pass zeroes the store,
//   during which no item is taken (register writes still work)
`default_nettype none
module rgba_source_over_pixel_blender_top #(
    parameter int MAX_WIDTH  = rgba_blend_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rgba_blend_pkg::DEF_MAX_HEIGHT
) (
    input  wire         aclk,
    input  wire         aresetn,
    // input channel
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [79:0] s_tdata,   // pos_x, pos_y, src_red, src_green, src_blue, src_alpha
    input  wire  [1:0]  s_tuser,   // req_type
    // result channel
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,   // out_red, out_green, out_blue, out_alpha
    output logic [1:0]  m_tuser,   // status
    // register port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rgba_blend_pkg::*;

    logic [8:0]  width_reg, height_reg;
    logic [23:0] bg_rgb_reg;
    logic        bg_en_reg;
    logic        wr_en;

    cmd_t        cmd;
    sts_t        sts;
    logic [1:0]  status;
    logic [7:0]  out_red, out_green, out_blue, out_alpha;

    // register file, written on the access phase
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 9'd256;
            height_reg <= 9'd256;
            bg_rgb_reg <= 24'd0;
            bg_en_reg  <= 1'b0;
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_WIDTH:  width_reg  <= pwdata[8:0];
                REG_HEIGHT: height_reg <= pwdata[8:0];
                REG_BG_RGB: bg_rgb_reg <= pwdata[23:0];
                REG_BG_EN:  bg_en_reg  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_WIDTH:  prdata = 32'(width_reg);
            REG_HEIGHT: prdata = 32'(height_reg);
            REG_BG_RGB: prdata = 32'(bg_rgb_reg);
            REG_BG_EN:  prdata = 32'(bg_en_reg);
            default:    prdata = 32'd0;
        endcase
    end

    // sequencer: walks each item through the datapath steps
    rgba_blend_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // store, multipliers, shared divider and result register
    rgba_blend_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .sts               (sts),
        .req_type          (s_tuser),
        .pos_x             (s_tdata[15:0]),
        .pos_y             (s_tdata[31:16]),
        .src_red           (s_tdata[39:32]),
        .src_green         (s_tdata[47:40]),
        .src_blue          (s_tdata[55:48]),
        .src_alpha         (s_tdata[72:56]),
        .canvas_width      (width_reg),
        .canvas_height     (height_reg),
        .background_rgb    (bg_rgb_reg),
        .background_enable (bg_en_reg),
        .status            (status),
        .out_red           (out_red),
        .out_green         (out_green),
        .out_blue          (out_blue),
        .out_alpha         (out_alpha)
    );

    assign m_tdata = {out_alpha, out_blue, out_green, out_red};
    assign m_tuser = status;

endmodule
`default_nettype wire
